// ===== design/segment_table_engine_macros.svh =====
// assertion macros shared by the segment table engine
`ifndef SEGMENT_TABLE_ENGINE_MACROS_SVH
`define SEGMENT_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define STE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segment table check failed");

// next-cycle implication, clocked on clk, off during reset
`define STE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segment table sequencing check failed");

`endif

// ===== design/ste_pkg.sv =====
// types and codes of the segment table engine
`default_nettype none
package ste_pkg;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_FIND   = 3'd2,
		OP_INNER  = 3'd3,
		OP_MARK   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_FULL     = 3'd1,
		STS_NULL     = 3'd2,
		STS_VIOL     = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} state_t;

	// request broadcast to every cell
	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] id;
		logic [31:0] addr;
		logic [31:0] len;
		logic        flag;
	} req_t;

	// table update strobes, already qualified by success
	typedef struct packed {
		logic add;
		logic remove;
		logic mark;
	} upd_t;

	// contents of one record as seen by the top
	typedef struct packed {
		logic [15:0] id;
		logic [31:0] start;
		logic [31:0] size;
		logic        loaded;
	} rec_t;

	// match result of one cell
	typedef struct packed {
		logic first;
		logic viol;
	} hit_t;

endpackage
`default_nettype wire

// ===== design/ste_cell.sv =====
// one record slot of the table with its compare logic and priority link
`default_nettype none
module ste_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ste_pkg::req_t    req,
	input  wire ste_pkg::upd_t    upd,
	input  wire logic             fire,
	input  wire logic [CNT_W-1:0] count,
	input  wire ste_pkg::rec_t    last_rec,
	input  wire logic             hit_in,
	output logic                  hit_out,
	output ste_pkg::hit_t         hit,
	output ste_pkg::rec_t         rec
);

	logic [15:0] id_q;
	logic [31:0] start_q;
	logic [31:0] size_q;
	logic        loaded_q;

	logic        valid;
	logic        match;
	logic        viol;
	logic [31:0] span;
	logic [31:0] diff;
	logic        at_start;
	logic        in_span;
	logic        is_tail;
	logic        is_slot;

	assign valid   = CNT_W'(INDEX) < count;
	assign is_slot = CNT_W'(INDEX) == count;
	assign is_tail = CNT_W'(INDEX + 1) == count;

	// range compare for the inner lookup
	assign span     = (req.len == 32'd0) ? size_q : req.len;
	assign diff     = req.addr - start_q;
	assign at_start = req.addr == start_q;
	assign in_span  = (req.addr > start_q) && (diff < span);

	// per-operation match
	always_comb begin
		match = 1'b0;
		viol  = 1'b0;
		unique case (ste_pkg::op_t'(req.op))
			ste_pkg::OP_REMOVE, ste_pkg::OP_MARK: match = id_q == req.id;
			ste_pkg::OP_FIND: match = at_start;
			ste_pkg::OP_INNER: begin
				match = at_start || in_span;
				viol  = at_start ? (req.len > size_q) : (span > size_q);
			end
			default: match = 1'b0;
		endcase
	end

	// priority link to the next cell
	assign hit_out = hit_in || (match && valid);
	assign hit     = '{first: match && valid && !hit_in, viol: viol};

	assign rec = '{id: id_q, start: start_q, size: size_q, loaded: loaded_q};

	// record payload
	always_ff @(posedge clk) begin
		if (fire) begin
			if (upd.add && is_slot) begin
				id_q    <= req.id;
				start_q <= req.addr;
				size_q  <= req.len;
			end else if (upd.remove && hit.first) begin
				id_q    <= last_rec.id;
				start_q <= last_rec.start;
				size_q  <= last_rec.size;
			end
		end
	end

	// loaded mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
		end else if (fire) begin
			if (upd.add && is_slot) begin
				loaded_q <= 1'b0;
			end else if (upd.remove && is_tail) begin
				loaded_q <= 1'b0;
			end else if (upd.remove && hit.first) begin
				loaded_q <= last_rec.loaded;
			end else if (upd.mark && hit.first) begin
				loaded_q <= req.flag;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/segment_table_engine.sv =====
// segment table engine top level: request capture, cell row, result register
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  req     | req_valid/req_stall | operation segment_id address length loaded_flag
//  rsp     | rsp_valid/rsp_stall | status found_id record_count loaded_count
//
// an item is captured in S_IDLE, then in S_EVAL the cell row compares
// all records at once and writes the table back while the result is registered.
// the row's priority link sets the compare path, one cell per record.
// reset empties the table and clears the loaded marks at once, no sweep.
// a stalled result holds the next item in its compare cycle.
`default_nettype none
`include "segment_table_engine_macros.svh"
module segment_table_engine #(
	parameter int MAX_RECORDS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [15:0] segment_id,
	input  wire logic [31:0] address,
	input  wire logic [31:0] length,
	input  wire logic        loaded_flag,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [2:0]       status,
	output logic [15:0]      found_id,
	output logic [4:0]       record_count,
	output logic [4:0]       loaded_count
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);

	ste_pkg::state_t state_q, state_d;
	ste_pkg::req_t   req_q;
	ste_pkg::upd_t   upd;
	ste_pkg::rec_t   recs [MAX_RECORDS];
	ste_pkg::hit_t   hits [MAX_RECORDS];
	ste_pkg::rec_t   last_rec;
	logic [MAX_RECORDS:0] link;
	logic [MAX_RECORDS-1:0] first_vec;

	logic [CNT_W-1:0] cnt_q, ld_q, cnt_d, ld_d;
	logic [IDX_W-1:0] last_idx;
	logic             req_fire, go, found, hit_viol;
	logic [15:0]      hit_id;
	logic [2:0]       sts_d;
	logic [15:0]      fid_d;
	logic             rsp_valid_q;
	logic [2:0]       status_q;
	logic [15:0]      found_id_q;
	logic [4:0]       record_count_q, loaded_count_q;

	assign req_stall = state_q == ste_pkg::S_EVAL;
	assign req_fire  = req_valid && !req_stall;
	assign go        = (state_q == ste_pkg::S_EVAL) && (!rsp_valid_q || !rsp_stall);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ste_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ste_pkg::S_IDLE: if (req_fire) state_d = ste_pkg::S_EVAL;
			ste_pkg::S_EVAL: if (go) state_d = ste_pkg::S_IDLE;
			default: state_d = ste_pkg::S_IDLE;
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= '{op: operation, id: segment_id, addr: address, len: length,
				flag: loaded_flag};
		end
	end

	// cell row, priority handed from cell to cell
	assign link[0]  = 1'b0;
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign last_rec = recs[last_idx];

	for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
		ste_cell #(.INDEX(g), .CNT_W(CNT_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (req_q),
			.upd      (upd),
			.fire     (go),
			.count    (cnt_q),
			.last_rec (last_rec),
			.hit_in   (link[g]),
			.hit_out  (link[g+1]),
			.hit      (hits[g]),
			.rec      (recs[g])
		);
		assign first_vec[g] = hits[g].first;
	end

	assign found = link[MAX_RECORDS];

	// pick the fields of the first matching cell
	always_comb begin
		hit_id   = '0;
		hit_viol = 1'b0;
		for (int i = 0; i < MAX_RECORDS; i++) begin
			if (hits[i].first) begin
				hit_id   = hit_id | recs[i].id;
				hit_viol = hit_viol | hits[i].viol;
			end
		end
	end

	// result and table update decision
	always_comb begin
		sts_d = ste_pkg::STS_NOTFOUND;
		fid_d = '0;
		upd   = '0;
		cnt_d = cnt_q;
		ld_d  = ld_q;
		unique case (ste_pkg::op_t'(req_q.op))
			ste_pkg::OP_ADD: begin
				if (req_q.id == 16'd0) begin
					sts_d = ste_pkg::STS_NULL;
				end else if (cnt_q >= MAX_CNT) begin
					sts_d = ste_pkg::STS_FULL;
				end else begin
					sts_d   = ste_pkg::STS_OK;
					fid_d   = req_q.id;
					upd.add = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			ste_pkg::OP_REMOVE, ste_pkg::OP_MARK: begin
				if (req_q.id == 16'd0) begin
					sts_d = ste_pkg::STS_NULL;
				end else if (found) begin
					sts_d = ste_pkg::STS_OK;
					fid_d = req_q.id;
					if (ste_pkg::op_t'(req_q.op) == ste_pkg::OP_REMOVE) begin
						upd.remove = 1'b1;
						cnt_d      = cnt_q - CNT_W'(1);
					end else begin
						upd.mark = 1'b1;
						if (req_q.flag) begin
							if (ld_q < MAX_CNT) ld_d = ld_q + CNT_W'(1);
						end else begin
							if (ld_q != '0) ld_d = ld_q - CNT_W'(1);
						end
					end
				end
			end
			ste_pkg::OP_FIND: begin
				if (found) begin
					sts_d = ste_pkg::STS_OK;
					fid_d = hit_id;
				end
			end
			ste_pkg::OP_INNER: begin
				if (found) begin
					sts_d = hit_viol ? ste_pkg::STS_VIOL : ste_pkg::STS_OK;
					fid_d = hit_id;
				end
			end
			default: sts_d = ste_pkg::STS_NOTFOUND;
		endcase
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ld_q  <= '0;
		end else if (go) begin
			cnt_q <= cnt_d;
			ld_q  <= ld_d;
		end
	end

	// result register, one transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q       <= sts_d;
			found_id_q     <= fid_d;
			record_count_q <= 5'(cnt_d);
			loaded_count_q <= 5'(ld_d);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign found_id     = found_id_q;
	assign record_count = record_count_q;
	assign loaded_count = loaded_count_q;

	// checks
	`STE_ASSERT_NOW(a_cnt_max, 1'b1, (cnt_q <= MAX_CNT) && (ld_q <= MAX_CNT))
	`STE_ASSERT_NOW(a_one_first, state_q == ste_pkg::S_EVAL, $onehot0(first_vec))
	`STE_ASSERT_NOW(a_found_first, go, found == (first_vec != '0))
	`STE_ASSERT_NEXT(a_fire_eval, req_fire, state_q == ste_pkg::S_EVAL)
	`STE_ASSERT_NEXT(a_go_rsp, go, rsp_valid)

endmodule
`default_nettype wire
